### sv/lscp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscp_pkg
// Shared types and constants of the line sensor centroid position block.
// ----------------------------------------------------------------------------
package lscp_pkg;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 10;
    localparam int POS_W       = 11;

    localparam int IDX_W = $clog2(CHANNELS);
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int SUM_W = $clog2(CHANNELS * (CHANNELS - 1) / 2 + 1);

    // Channel i weighs 10*i; Q4 scales that by 16
    localparam int WEIGHT_Q4    = 160;
    localparam int CENTRE_Q4    = 80 * (CHANNELS - 1);
    localparam int MAX_DIVIDEND = WEIGHT_Q4 * CHANNELS * (CHANNELS - 1) / 2;
    localparam int DIV_W        = $clog2(MAX_DIVIDEND + 1);
    localparam int STEP_W       = $clog2(DIV_W + 1);

    localparam logic [SAMPLE_BITS-1:0] WHITE_RESET = SAMPLE_BITS'(950);
    localparam logic [SAMPLE_BITS-1:0] BLACK_RESET = SAMPLE_BITS'(900);

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        KIND_MEASURE = 2'd0,
        KIND_WHITE   = 2'd1,
        KIND_BLACK   = 2'd2,
        KIND_IGNORE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DIVIDE = 2'd2,
        ST_DONE   = 2'd3
    } state_t;

    typedef struct packed {
        kind_t   kind;
        sample_t sample0;
        sample_t sample1;
        sample_t sample2;
        sample_t sample3;
        sample_t sample4;
        sample_t sample5;
        sample_t sample6;
        sample_t sample7;
    } in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position_q4;
        logic                    line_seen;
        logic [CHANNELS-1:0]     black_mask;
    } out_t;

endpackage

### sv/line_sensor_centroid_position.sv
`timescale 1ns / 1ps
// Sequence: a capture or ignored frame goes from acceptance straight to the result;
// a measure frame is scanned first, and one with a black channel is then divided.
// Frames do not overlap (s_ready only in idle). The scan runs one channel per cycle
// through the shared classifier; the restoring divider takes 13 one-bit steps.
// Reset: aresetn synchronous, active low; references return to 950 white / 900 black,
// the held position to zero, and no result is pending.
// ----------------------------------------------------------------------------
// line_sensor_centroid_position
// Classifies an eight-channel reflectance frame against stored references and
// reports the centroid of the black channels as a Q4 line position.
// ----------------------------------------------------------------------------
module line_sensor_centroid_position (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lscp_pkg::in_t    s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output lscp_pkg::out_t   m_payload
);

    localparam logic [lscp_pkg::IDX_W-1:0] LAST_IDX = lscp_pkg::IDX_W'(lscp_pkg::CHANNELS - 1);

    // ---------------------------------------------------------------- state
    lscp_pkg::state_t state_reg;
    lscp_pkg::state_t state_next;

    // Frame under work and the two reference sets
    lscp_pkg::sample_t frame_reg [lscp_pkg::CHANNELS];
    lscp_pkg::sample_t white_reg [lscp_pkg::CHANNELS];
    lscp_pkg::sample_t black_reg [lscp_pkg::CHANNELS];
    lscp_pkg::sample_t in_samples [lscp_pkg::CHANNELS];

    // Scan accumulators
    logic [lscp_pkg::IDX_W-1:0]    idx_reg;
    logic [lscp_pkg::SUM_W-1:0]    sum_reg;
    logic [lscp_pkg::SUM_W-1:0]    sum_next;
    logic [lscp_pkg::CNT_W-1:0]    count_reg;
    logic [lscp_pkg::CNT_W-1:0]    count_next;
    logic [lscp_pkg::CHANNELS-1:0] mask_reg;

    logic signed [lscp_pkg::POS_W-1:0] held_reg;

    // Output register
    logic           m_valid_reg;
    lscp_pkg::out_t m_payload_reg;

    // Control strobes
    logic accept;
    logic out_free;
    logic scan_en;
    logic div_start;
    logic out_load;

    logic                               is_black;
    logic                               div_done;
    logic [lscp_pkg::DIV_W-1:0]         div_quotient;
    logic [lscp_pkg::DIV_W-1:0]         dividend;
    logic signed [lscp_pkg::DIV_W:0]    pos_wide;

    // Unpack the transaction payload into a channel array
    always_comb begin
        in_samples[0] = s_payload.sample0;
        in_samples[1] = s_payload.sample1;
        in_samples[2] = s_payload.sample2;
        in_samples[3] = s_payload.sample3;
        in_samples[4] = s_payload.sample4;
        in_samples[5] = s_payload.sample5;
        in_samples[6] = s_payload.sample6;
        in_samples[7] = s_payload.sample7;
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------- shared classifier
    // One channel per cycle, chosen by the scan index
    lscp_classify u_classify (
        .sample    (frame_reg[idx_reg]),
        .white_ref (white_reg[idx_reg]),
        .black_ref (black_reg[idx_reg]),
        .is_black  (is_black)
    );

    always_comb begin
        sum_next   = sum_reg + (is_black ? lscp_pkg::SUM_W'(idx_reg) : '0);
        count_next = count_reg + lscp_pkg::CNT_W'(is_black);
        // 16 * 10 * (sum of black indices)
        dividend   = lscp_pkg::DIV_W'(sum_next) * lscp_pkg::DIV_W'(lscp_pkg::WEIGHT_Q4);
    end

    // ------------------------------------------------------------ divider
    lscp_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Remove the array centre; result always fits the Q4 field
    assign pos_wide = $signed({1'b0, div_quotient})
                    - $signed((lscp_pkg::DIV_W + 1)'(lscp_pkg::CENTRE_Q4));

    // ------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lscp_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_payload.kind == lscp_pkg::KIND_MEASURE) ?
                                 lscp_pkg::ST_SCAN : lscp_pkg::ST_DONE;
                end
            end
            lscp_pkg::ST_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = (count_next != '0) ? lscp_pkg::ST_DIVIDE : lscp_pkg::ST_DONE;
                end
            end
            lscp_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = lscp_pkg::ST_DONE;
                end
            end
            lscp_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = lscp_pkg::ST_IDLE;
                end
            end
            default: state_next = lscp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        scan_en   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            lscp_pkg::ST_IDLE:   s_ready = 1'b1;
            lscp_pkg::ST_SCAN: begin
                scan_en   = 1'b1;
                div_start = (idx_reg == LAST_IDX) && (count_next != '0);
            end
            lscp_pkg::ST_DIVIDE: ;
            lscp_pkg::ST_DONE:   out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lscp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------- reference store
    // Captures overwrite every channel of one set at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lscp_pkg::CHANNELS; i++) begin
                white_reg[i] <= lscp_pkg::WHITE_RESET;
                black_reg[i] <= lscp_pkg::BLACK_RESET;
            end
        end else if (accept) begin
            if (s_payload.kind == lscp_pkg::KIND_WHITE) begin
                white_reg <= in_samples;
            end
            if (s_payload.kind == lscp_pkg::KIND_BLACK) begin
                black_reg <= in_samples;
            end
        end
    end

    // ----------------------------------------------------- scan datapath
    // Clear the accumulators on every transaction so captures report an empty mask
    always_ff @(posedge aclk) begin
        if (accept) begin
            frame_reg <= in_samples;
            idx_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            mask_reg  <= '0;
        end else if (scan_en) begin
            mask_reg[idx_reg] <= is_black;
            sum_reg           <= sum_next;
            count_reg         <= count_next;
            idx_reg           <= idx_reg + 1'b1;
        end
    end

    // Hold the last position until a frame finds the line again
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (state_reg == lscp_pkg::ST_DIVIDE && div_done) begin
            held_reg <= pos_wide[lscp_pkg::POS_W-1:0];
        end
    end

    // ---------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg.position_q4 <= held_reg;
            m_payload_reg.line_seen   <= (count_reg != '0);
            m_payload_reg.black_mask  <= mask_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    a_capture_skips_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_payload.kind != lscp_pkg::KIND_MEASURE) |=> state_reg == lscp_pkg::ST_DONE)
        else $error("capture transaction did not go straight to result");

    a_no_line_empty_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.line_seen) |-> m_payload.black_mask == '0)
        else $error("mask set on a result without a line");

    a_line_has_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.line_seen) |-> m_payload.black_mask != '0)
        else $error("line reported with an empty mask");

    a_div_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == lscp_pkg::ST_DIVIDE)
        else $error("divider finished outside the divide state");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lscp_pkg::ST_SCAN) |-> count_reg <= lscp_pkg::CNT_W'(idx_reg))
        else $error("black count exceeds channels scanned");
`endif

endmodule

### sv/lscp_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscp_classify
// Shared channel classifier: black when strictly nearer the black reference.
// ----------------------------------------------------------------------------
module lscp_classify (
    input  lscp_pkg::sample_t sample,
    input  lscp_pkg::sample_t white_ref,
    input  lscp_pkg::sample_t black_ref,
    output logic              is_black
);

    lscp_pkg::sample_t dist_white;
    lscp_pkg::sample_t dist_black;

    always_comb begin
        dist_white = (sample > white_ref) ? (sample - white_ref) : (white_ref - sample);
        dist_black = (sample > black_ref) ? (sample - black_ref) : (black_ref - sample);
        // Equal distances class as white
        is_black   = (dist_black < dist_white);
    end

endmodule

### sv/lscp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscp_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lscp_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lscp_pkg::DIV_W-1:0]   dividend,
    input  logic [lscp_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic [lscp_pkg::DIV_W-1:0]   quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [lscp_pkg::STEP_W-1:0]   step_reg;
    logic [lscp_pkg::CNT_W-1:0]    rem_reg;
    logic [lscp_pkg::CNT_W-1:0]    dsr_reg;
    logic [lscp_pkg::DIV_W-1:0]    quo_reg;

    logic [lscp_pkg::CNT_W:0]      trial;
    logic [lscp_pkg::CNT_W:0]      diff;
    logic                          q_bit;

    always_comb begin
        trial = {rem_reg, quo_reg[lscp_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        q_bit = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= lscp_pkg::STEP_W'(lscp_pkg::DIV_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == lscp_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift dividend bits out at the top, quotient bits in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= q_bit ? diff[lscp_pkg::CNT_W-1:0] : trial[lscp_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[lscp_pkg::DIV_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
